// File: hw/rtl/bfc_pkg.sv
// Shared types, register codes and defaults for the box frustum cull block.
// No dependencies; every other file of the block imports it.
package bfc_pkg;

  localparam int DefFracBits = 16;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAT_A  = 3'd0,
    REG_MAT_B  = 3'd1,
    REG_MAT_C  = 3'd2,
    REG_MAT_D  = 3'd3,
    REG_MAT_E  = 3'd4,
    REG_MAT_F  = 3'd5,
    REG_NEAR   = 3'd6,
    REG_SCALES = 3'd7
  } cfg_reg_e;

  localparam logic [63:0] MatDiagReset = 64'd65536;
  localparam logic [30:0] NearReset    = 31'd6554;

  // One queued box: corners plus per-axis extent magnitude
  typedef struct packed {
    logic [2:0][31:0] mn;
    logic [2:0][31:0] mx;
    logic [2:0][31:0] ext;
  } box_t;

  // Decoded configuration, near already forced to at least one step
  typedef struct packed {
    logic [2:0][2:0][31:0] m;
    logic [2:0][31:0]      tr;
    logic [31:0]           near;
    logic [31:0]           sx;
    logic [31:0]           sy;
  } cfg_t;

  // Per-corner control that rides along the back pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic unpulled;
  } tag_t;

endpackage

// File: hw/rtl/bfc_front.sv
// Front end: accepts boxes, works out the axis extents and queues them.
// Depends on bfc_pkg.
module bfc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0][31:0]        mn_i,
  input  logic [2:0][31:0]        mx_i,
  output logic                    entry_valid_o,
  output bfc_pkg::box_t           entry_o,
  input  logic                    pop_i
);
  import bfc_pkg::*;

  box_t        mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;
  box_t        box_new;

  // Form extents as |max - min|
  always_comb begin
    logic signed [32:0] diff;
    box_new.mn = mn_i;
    box_new.mx = mx_i;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({mx_i[k][31], mx_i[k]}) - $signed({mn_i[k][31], mn_i[k]});
      box_new.ext[k] = diff[32] ? 32'(-diff) : diff[31:0];
    end
  end

  assign in_ready_o    = (cnt_q != 2'd2);
  assign push          = in_valid_i && in_ready_o;
  assign entry_valid_o = (cnt_q != 2'd0);
  assign entry_o       = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  // Store the transaction
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= box_new;
  end

endmodule

// File: hw/rtl/bfc_xform.sv
// Corner sequencer and view transform: one corner per cycle, while en_i is high,
// through the matrix product, near clamp and projection scale. Depends on bfc_pkg.
module bfc_xform #(
  parameter int FRAC_BITS = bfc_pkg::DefFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 entry_valid_i,
  input  bfc_pkg::box_t        entry_i,
  output logic                 pop_o,
  input  bfc_pkg::cfg_t        cfg_i,
  output logic signed [63:0]   num_x_o,
  output logic signed [63:0]   num_y_o,
  output logic [31:0]          den_o,
  output bfc_pkg::tag_t        tag_o
);
  import bfc_pkg::*;

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = PW + 2;

  logic [2:0]         cnt_q;
  tag_t               t0_q, t1_q, t2_q, t3_q, t4_q;
  logic signed [31:0] c_q [3];
  logic signed [PW-1:0] p_q [3][3];
  logic signed [31:0] v_q [3];
  logic signed [31:0] w0_q, w1_q;
  logic [31:0]        dm_q, den_q;
  logic signed [63:0] nx_q, ny_q;
  logic               start;

  assign start = en_i && entry_valid_i;
  assign pop_o = start && (cnt_q == 3'd7);

  // Step through the eight corners of the queued box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      t0_q  <= '0;
      t1_q  <= '0;
      t2_q  <= '0;
      t3_q  <= '0;
      t4_q  <= '0;
    end else if (en_i) begin
      if (start) cnt_q <= cnt_q + 3'd1;
      t0_q.valid    <= start;
      t0_q.first    <= (cnt_q == 3'd0);
      t0_q.last     <= (cnt_q == 3'd7);
      t0_q.unpulled <= 1'b0;
      t1_q <= t0_q;
      t2_q <= t1_q;
      t3_q.valid    <= t2_q.valid;
      t3_q.first    <= t2_q.first;
      t3_q.last     <= t2_q.last;
      t3_q.unpulled <= !($signed({v_q[2][31], v_q[2]}) > -$signed({1'b0, cfg_i.near}));
      t4_q <= t3_q;
    end
  end

  // Corner coordinates, saturated to 32 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [33:0] s;
        logic               alt;
        alt = (k == 0) ? cnt_q[1] : cnt_q[0];
        if (!cnt_q[2]) begin
          s = $signed({{2{entry_i.mx[k][31]}}, entry_i.mx[k]});
          if (alt && k != 2) s = s - $signed({2'b00, entry_i.ext[k]});
        end else begin
          s = $signed({{2{entry_i.mn[k][31]}}, entry_i.mn[k]});
          if (alt && k != 2) s = s + $signed({2'b00, entry_i.ext[k]});
        end
        c_q[k] <= (&s[33:31] || ~|s[33:31]) ? s[31:0] : {s[33], {31{~s[33]}}};
      end
    end
  end

  // Matrix products, floored by the fraction shift
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          logic signed [63:0] pr;
          pr = c_q[r] * $signed(cfg_i.m[r][k]);
          p_q[r][k] <= pr[63:FRAC_BITS];
        end
      end
    end
  end

  // Sum with translation and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [SW-1:0] s;
        s = SW'(p_q[0][k]) + SW'(p_q[1][k]) + SW'(p_q[2][k]) +
            SW'($signed(cfg_i.tr[k]));
        v_q[k] <= (&s[SW-1:31] || ~|s[SW-1:31]) ? s[31:0] : {s[SW-1], {31{~s[SW-1]}}};
      end
    end
  end

  // Pull depth back to the near plane; keep depth magnitude
  always_ff @(posedge clk_i) begin
    logic signed [32:0] dn;
    if (en_i) begin
      w0_q <= v_q[0];
      w1_q <= v_q[1];
      if ($signed({v_q[2][31], v_q[2]}) > -$signed({1'b0, cfg_i.near})) begin
        dm_q <= cfg_i.near;
      end else begin
        dn = -$signed({v_q[2][31], v_q[2]});
        dm_q <= dn[31:0];
      end
    end
  end

  // Projection scale products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q  <= w0_q * $signed(cfg_i.sx);
      ny_q  <= w1_q * $signed(cfg_i.sy);
      den_q <= dm_q;
    end
  end

  assign num_x_o = nx_q;
  assign num_y_o = ny_q;
  assign den_o   = den_q;
  assign tag_o   = t4_q;

endmodule

// File: hw/rtl/bfc_div.sv
// Pipelined restoring divider: numerator over negative depth, quotient
// truncated toward zero and clamped to [-1, 1]. Depends on bfc_pkg.
module bfc_div #(
  parameter int FRAC_BITS = bfc_pkg::DefFracBits
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [63:0]          num_i,
  input  logic [31:0]                 den_i,
  output logic signed [FRAC_BITS+1:0] res_o
);
  import bfc_pkg::*;

  localparam int NS = FRAC_BITS + 1;

  logic [63:0]    mag_q;
  logic           neg_a_q;
  logic [31:0]    den_a_q;
  logic [63:0]    r_q   [NS+1];
  logic [31:0]    d_q   [NS+1];
  logic [NS-1:0]  q_q   [NS+1];
  logic           sat_q [NS+1];
  logic           neg_q [NS+1];

  // Take magnitude; a positive numerator gives a negative quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= num_i[63] ? 64'(-num_i) : num_i;
      neg_a_q <= (num_i > 64'sd0);
      den_a_q <= den_i;
    end
  end

  // Flag quotients too large to survive the clamp
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= mag_q;
      d_q[0]   <= den_a_q;
      q_q[0]   <= '0;
      sat_q[0] <= (mag_q >= ({32'd0, den_a_q} << NS));
      neg_q[0] <= neg_a_q;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [63:0] sh;
    logic        ge;
    assign sh = {32'd0, d_q[k]} << (NS - 1 - k);
    assign ge = (r_q[k] >= sh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? r_q[k] - sh : r_q[k];
        d_q[k+1]   <= d_q[k];
        q_q[k+1]   <= {q_q[k][NS-2:0], ge};
        sat_q[k+1] <= sat_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // Apply sign and clamp to one
  always_comb begin
    logic [FRAC_BITS+1:0]        mag;
    logic signed [FRAC_BITS+2:0] val;
    mag = sat_q[NS] ? (FRAC_BITS+2)'(1) << NS : {1'b0, q_q[NS]};
    val = neg_q[NS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (val > $signed((FRAC_BITS+3)'(1) << FRAC_BITS)) begin
      res_o = (FRAC_BITS+2)'(1) << FRAC_BITS;
    end else if (val < -$signed((FRAC_BITS+3)'(1) << FRAC_BITS)) begin
      res_o = -$signed((FRAC_BITS+2)'(1) << FRAC_BITS);
    end else begin
      res_o = val[FRAC_BITS+1:0];
    end
  end

endmodule

// File: hw/rtl/box_frustum_cull.sv
// Box frustum cull top level: configuration registers, front queue, transform,
// two projection dividers and the extrema accumulator.
// Throughput: one corner per cycle while no result waits; eight corners per box.
// Reset: matrix to identity, near to 6554, scales to zero, queue and pipeline empty.
module box_frustum_cull #(
  parameter int FRAC_BITS = bfc_pkg::DefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bfc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            box_min_x_i,
  input  logic signed [31:0]            box_min_y_i,
  input  logic signed [31:0]            box_min_z_i,
  input  logic signed [31:0]            box_max_x_i,
  input  logic signed [31:0]            box_max_y_i,
  input  logic signed [31:0]            box_max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          visible_o
);
  import bfc_pkg::*;

  localparam int DL = FRAC_BITS + 3;
  localparam int VW = FRAC_BITS + 2;

  logic [63:0] mat_q [6];
  logic [30:0] near_q;
  logic [63:0] scl_q;
  cfg_t        cfg;
  logic        en;
  logic        entry_valid, pop;
  box_t        entry;
  logic signed [63:0] num_x, num_y;
  logic [31:0] den;
  tag_t        tag_x;
  tag_t        tag_q [DL];
  logic signed [VW-1:0] px, py;
  logic signed [VW-1:0] xmax_q, xmin_q, ymax_q, ymin_q;
  logic        unp_q, out_valid_q, visible_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= MatDiagReset;
      mat_q[1] <= '0;
      mat_q[2] <= MatDiagReset;
      mat_q[3] <= '0;
      mat_q[4] <= MatDiagReset;
      mat_q[5] <= '0;
      near_q   <= NearReset;
      scl_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAT_A:  mat_q[0] <= cfg_data_i;
        REG_MAT_B:  mat_q[1] <= cfg_data_i;
        REG_MAT_C:  mat_q[2] <= cfg_data_i;
        REG_MAT_D:  mat_q[3] <= cfg_data_i;
        REG_MAT_E:  mat_q[4] <= cfg_data_i;
        REG_MAT_F:  mat_q[5] <= cfg_data_i;
        REG_NEAR:   near_q   <= cfg_data_i[30:0];
        REG_SCALES: scl_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack matrix halves; a zero near distance acts as one step
  always_comb begin
    cfg.m[0][0] = mat_q[0][31:0];
    cfg.m[0][1] = mat_q[0][63:32];
    cfg.m[0][2] = mat_q[1][31:0];
    cfg.m[1][0] = mat_q[1][63:32];
    cfg.m[1][1] = mat_q[2][31:0];
    cfg.m[1][2] = mat_q[2][63:32];
    cfg.m[2][0] = mat_q[3][31:0];
    cfg.m[2][1] = mat_q[3][63:32];
    cfg.m[2][2] = mat_q[4][31:0];
    cfg.tr[0]   = mat_q[4][63:32];
    cfg.tr[1]   = mat_q[5][31:0];
    cfg.tr[2]   = mat_q[5][63:32];
    cfg.near    = (near_q == '0) ? 32'd1 : {1'b0, near_q};
    cfg.sx      = scl_q[31:0];
    cfg.sy      = scl_q[63:32];
  end

  // Back pipeline moves whenever the result register can take a value
  assign en = !out_valid_q || out_ready_i;

  bfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mn_i          ({box_min_z_i, box_min_y_i, box_min_x_i}),
    .mx_i          ({box_max_z_i, box_max_y_i, box_max_x_i}),
    .entry_valid_o (entry_valid),
    .entry_o       (entry),
    .pop_i         (pop)
  );

  bfc_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .cfg_i         (cfg),
    .num_x_o       (num_x),
    .num_y_o       (num_y),
    .den_o         (den),
    .tag_o         (tag_x)
  );

  bfc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_x),
    .den_i (den),
    .res_o (px)
  );

  bfc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_y),
    .den_i (den),
    .res_o (py)
  );

  // Delay corner tags to match the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) tag_q[k] <= '0;
    end else if (en) begin
      tag_q[0] <= tag_x;
      for (int k = 1; k < DL; k++) tag_q[k] <= tag_q[k-1];
    end
  end

  // Accumulate extrema and emit the verdict on the last corner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [VW-1:0] nxmax, nxmin, nymax, nymin;
    logic                 nunp;
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      visible_q   <= 1'b0;
      unp_q       <= 1'b0;
      xmax_q      <= '0;
      xmin_q      <= '0;
      ymax_q      <= '0;
      ymin_q      <= '0;
    end else if (en) begin
      if (tag_q[DL-1].first) begin
        nxmax = px;
        nxmin = px;
        nymax = py;
        nymin = py;
        nunp  = tag_q[DL-1].unpulled;
      end else begin
        nxmax = (px > xmax_q) ? px : xmax_q;
        nxmin = (px < xmin_q) ? px : xmin_q;
        nymax = (py > ymax_q) ? py : ymax_q;
        nymin = (py < ymin_q) ? py : ymin_q;
        nunp  = unp_q || tag_q[DL-1].unpulled;
      end
      if (tag_q[DL-1].valid) begin
        xmax_q <= nxmax;
        xmin_q <= nxmin;
        ymax_q <= nymax;
        ymin_q <= nymin;
        unp_q  <= nunp;
      end
      out_valid_q <= tag_q[DL-1].valid && tag_q[DL-1].last;
      visible_q   <= (nxmax > nxmin) && (nymax > nymin) && nunp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

endmodule
